### src/tssm_pkg.sv
// ----------------------------------------------------------------------------
// tssm_pkg
// Shared types and constants for the two-stack shared-memory block.
// ----------------------------------------------------------------------------
package tssm_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned WordWidth    = 32;

  localparam logic [WordWidth-1:0] UnderflowWord = '1;

  typedef enum logic [1:0] {
    CmdPushOne = 2'd0,
    CmdPushTwo = 2'd1,
    CmdPopOne  = 2'd2,
    CmdPopTwo  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StOverflow  = 2'd1,
    StUnderflow = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CtlIdle,
    CtlExec,
    CtlRead
  } ctl_state_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic signed [WordWidth-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] pop_value;
    status_e                     status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;   // capture the accepted item
    logic exec;      // run the command: pointer update, memory access
    logic load_rd;   // move read data into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_read; // held command is a pop of a non-empty stack
  } dp_status_t;

endpackage

### src/two_stacks_shared_memory.sv
// ----------------------------------------------------------------------------
// two_stacks_shared_memory
// Two LIFO stacks sharing one DEPTH-word memory, growing toward each other.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one command
//   per item: push to stack one or two, or pop from stack one or two.
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns exactly
//   one result per item: the popped word and a status (ok, overflow on a
//   push into a full memory, underflow with all-ones word on an empty pop).
//   A push or a refused command runs in the execute state and its result
//   goes straight into the output register; a successful pop also passes
//   through the registered read of the shared memory port first.
//   The input is stalled while an item is being run by the sequencer, so a
//   new item is taken only once the previous one has reached the output register.
//   A new item is accepted while the previous result still waits in the
//   output register; its command runs only once that register is free.
//   When the receiver stalls, the result holds and the block stalls after
//   taking at most one more item.
//   Reset: both stacks empty, output channel empty; memory contents are
//   left as they are and are only read after being written.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory #(
  parameter int unsigned DEPTH = tssm_pkg::DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tssm_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tssm_pkg::out_item_t  out_item_o
);
  import tssm_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  tssm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  tssm_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .dp_cmd_i    (dp_cmd),
    .dp_status_o (dp_status)
  );

endmodule

### src/tssm_ctrl.sv
// ----------------------------------------------------------------------------
// tssm_ctrl
// Sequencer: accepts an item, runs it once the output register is free,
// waits for the memory read on a non-empty pop, and tracks output valid.
// ----------------------------------------------------------------------------
module tssm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  tssm_pkg::dp_status_t  dp_status_i,
  output tssm_pkg::dp_cmd_t     dp_cmd_o
);
  import tssm_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       out_load;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    out_load = 1'b0;
    unique case (state_q)
      CtlIdle: begin
        if (in_valid_i) begin
          dp_cmd_o.load_in = 1'b1;
          state_d          = CtlExec;
        end
      end
      CtlExec: begin
        // hold until the output register can take a result
        if (out_free) begin
          dp_cmd_o.exec = 1'b1;
          if (dp_status_i.need_read) begin
            state_d = CtlRead;
          end else begin
            out_load = 1'b1;
            state_d  = CtlIdle;
          end
        end
      end
      CtlRead: begin
        // output register was emptied on the way here
        dp_cmd_o.load_rd = 1'b1;
        out_load         = 1'b1;
        state_d          = CtlIdle;
      end
      default: state_d = CtlIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtlIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != CtlIdle);
  assign out_valid_o = out_valid_q;

endmodule

### src/tssm_datapath.sv
// ----------------------------------------------------------------------------
// tssm_datapath
// Shared word memory, the two stack pointers, the held item and the output
// register.
// ----------------------------------------------------------------------------
module tssm_datapath #(
  parameter int unsigned DEPTH = tssm_pkg::DefaultDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tssm_pkg::in_item_t    in_item_i,
  output tssm_pkg::out_item_t   out_item_o,
  input  tssm_pkg::dp_cmd_t     dp_cmd_i,
  output tssm_pkg::dp_status_t  dp_status_o
);
  import tssm_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] TopCount = CW'(DEPTH);

  logic [WordWidth-1:0] mem_q [DEPTH];

  in_item_t             item_q;
  out_item_t            out_q, out_d;
  logic [CW-1:0]        low_count_q, low_count_d;
  logic [CW-1:0]        high_base_q, high_base_d;
  logic [WordWidth-1:0] rd_data_q;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 has_room, one_empty, two_empty;
  logic [CW-1:0]        low_dec, high_dec;

  assign has_room  = (low_count_q < high_base_q);
  assign one_empty = (low_count_q == '0);
  assign two_empty = (high_base_q == TopCount);
  assign low_dec   = low_count_q - CW'(1);
  assign high_dec  = high_base_q - CW'(1);

  always_comb begin
    low_count_d = low_count_q;
    high_base_d = high_base_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = low_dec[AW-1:0];
    wr_addr     = low_count_q[AW-1:0];
    out_d       = out_q;
    dp_status_o.need_read = 1'b0;
    unique case (item_q.cmd)
      CmdPushOne: begin
        wr_addr = low_count_q[AW-1:0];
        if (dp_cmd_i.exec) begin
          out_d.pop_value = '0;
          out_d.status    = has_room ? StOk : StOverflow;
          if (has_room) begin
            wr_en       = 1'b1;
            low_count_d = low_count_q + CW'(1);
          end
        end
      end
      CmdPushTwo: begin
        wr_addr = high_dec[AW-1:0];
        if (dp_cmd_i.exec) begin
          out_d.pop_value = '0;
          out_d.status    = has_room ? StOk : StOverflow;
          if (has_room) begin
            wr_en       = 1'b1;
            high_base_d = high_dec;
          end
        end
      end
      CmdPopOne: begin
        rd_addr = low_dec[AW-1:0];
        dp_status_o.need_read = !one_empty;
        if (dp_cmd_i.exec) begin
          if (one_empty) begin
            out_d.pop_value = UnderflowWord;
            out_d.status    = StUnderflow;
          end else begin
            rd_en       = 1'b1;
            low_count_d = low_dec;
          end
        end
      end
      CmdPopTwo: begin
        rd_addr = high_base_q[AW-1:0];
        dp_status_o.need_read = !two_empty;
        if (dp_cmd_i.exec) begin
          if (two_empty) begin
            out_d.pop_value = UnderflowWord;
            out_d.status    = StUnderflow;
          end else begin
            rd_en       = 1'b1;
            high_base_d = high_base_q + CW'(1);
          end
        end
      end
      default: ;
    endcase
    if (dp_cmd_i.load_rd) begin
      out_d.pop_value = rd_data_q;
      out_d.status    = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_count_q <= '0;
      high_base_q <= TopCount;
    end else begin
      low_count_q <= low_count_d;
      high_base_q <= high_base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_in) item_q <= in_item_i;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= item_q.push_value;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  assign out_item_o = out_q;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the two-stack shared-memory block against a shadow copy of both
// stacks: every accepted command is predicted, and each result is compared
// with the oldest prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import tssm_pkg::*;

  localparam int unsigned Depth      = DefaultDepth;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned MaxReports = 20;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item  = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_item_t out_item_o;

  // shadow of the shared store and both stack pointers
  logic [WordWidth-1:0] shadow_words [Depth];
  int unsigned          lower_fill = 0;
  int unsigned          upper_base = Depth;

  out_item_t   pending_results [$];
  int unsigned error_count = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_hold_req = 0;
  bit          gaps_on     = 1'b1;
  bit          offering    = 1'b0;

  two_stacks_shared_memory #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    end
  endtask

  function automatic out_item_t stack_result(input in_item_t item);
    out_item_t res;
    res.pop_value = '0;
    res.status    = StOk;
    case (item.cmd)
      CmdPushOne: begin
        if (lower_fill < upper_base) begin
          shadow_words[lower_fill] = item.push_value;
          lower_fill++;
        end else begin
          res.status = StOverflow;
        end
      end
      CmdPushTwo: begin
        if (lower_fill < upper_base) begin
          upper_base--;
          shadow_words[upper_base] = item.push_value;
        end else begin
          res.status = StOverflow;
        end
      end
      CmdPopOne: begin
        if (lower_fill > 0) begin
          lower_fill--;
          res.pop_value = shadow_words[lower_fill];
        end else begin
          res.status    = StUnderflow;
          res.pop_value = UnderflowWord;
        end
      end
      default: begin
        if (upper_base < Depth) begin
          res.pop_value = shadow_words[upper_base];
          upper_base++;
        end else begin
          res.status    = StUnderflow;
          res.pop_value = UnderflowWord;
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic stop_offering();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_item(input in_item_t item);
    in_item  <= item;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    pending_results.push_back(stack_result(item));
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          stop_offering();
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic issue(input cmd_e cmd, input logic [31:0] word);
    in_item_t item;
    item.cmd        = cmd;
    item.push_value = word;
    send_item(item);
    pace_sender();
  endtask

  // hold off new items until every pending result has come back
  task automatic drain_results();
    stop_offering();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    issue(CmdPopOne, random_word());
    issue(CmdPopTwo, random_word());
    issue(CmdPushOne, 32'h7FFF_FFFF);
    issue(CmdPushOne, 32'h8000_0000);
    issue(CmdPushTwo, 32'h0000_0000);
    issue(CmdPushTwo, 32'hFFFF_FFFF);
    issue(CmdPushOne, 32'h5555_5555);
    issue(CmdPushTwo, 32'hAAAA_AAAA);
    issue(CmdPopTwo, random_word());
    issue(CmdPopOne, random_word());
    issue(CmdPopOne, random_word());
    issue(CmdPopOne, random_word());
    issue(CmdPopOne, random_word());
    issue(CmdPopTwo, random_word());
    issue(CmdPopTwo, random_word());
    issue(CmdPopTwo, random_word());
    drain_results();
  endtask

  // one stack takes the whole store; the other sees full and empty at once
  task automatic test_fill_one_side(input cmd_e push_cmd, input cmd_e pop_cmd,
                                    input cmd_e other_push, input cmd_e other_pop);
    repeat (Depth) issue(push_cmd, random_word());
    issue(push_cmd, random_word());
    issue(other_push, random_word());
    issue(other_pop, random_word());
    repeat (Depth) issue(pop_cmd, random_word());
    issue(pop_cmd, random_word());
    drain_results();
  endtask

  // both stacks grow until they meet, then drain from random sides
  task automatic test_stacks_meet();
    gaps_on = 1'b0;
    while (lower_fill < upper_base) begin
      issue($urandom_range(0, 1) ? CmdPushTwo : CmdPushOne, random_word());
    end
    gaps_on = 1'b1;
    issue(CmdPushOne, random_word());
    issue(CmdPushTwo, random_word());
    while (lower_fill > 0 || upper_base < Depth) begin
      issue($urandom_range(0, 1) ? CmdPopTwo : CmdPopOne, random_word());
    end
    issue(CmdPopOne, random_word());
    issue(CmdPopTwo, random_word());
    drain_results();
  endtask

  task automatic test_random_mix(input int unsigned n_items);
    int unsigned push_pct;
    int unsigned two_pct;
    int unsigned phase_left;
    bit          do_push;
    bit          side_two;
    phase_left = 0;
    push_pct   = 50;
    two_pct    = 50;
    repeat (n_items) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 4))
          0:       push_pct = 90;
          1:       push_pct = 70;
          2:       push_pct = 50;
          3:       push_pct = 30;
          default: push_pct = 10;
        endcase
        two_pct    = $urandom_range(0, 2) * 50;
        phase_left = $urandom_range(20, 120);
        gaps_on    = ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      do_push  = ($urandom_range(0, 99) < push_pct);
      side_two = ($urandom_range(0, 99) < two_pct) || ($urandom_range(0, 9) == 0);
      if (do_push) begin
        issue(side_two ? CmdPushTwo : CmdPushOne, random_word());
      end else begin
        issue(side_two ? CmdPopTwo : CmdPopOne, random_word());
      end
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    gaps_on     = 1'b0;
    rx_hold_req = HoldCycles;
    repeat (40) issue(cmd_e'($urandom_range(0, 3)), random_word());
    gaps_on = 1'b1;
    drain_results();
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(30, 150);
      end
      mode_left--;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 0);
          2:       out_stall <= ((mode_left % 5) < 2);
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  initial begin : result_check
    out_item_t want;
    forever begin
      @(posedge clk);
      if (out_valid_o === 1'b1 && out_stall == 1'b0) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", '0, out_item_o.pop_value);
        end else begin
          want = pending_results.pop_front();
          if (out_item_o.pop_value !== want.pop_value) begin
            report_mismatch("pop_value", want.pop_value, out_item_o.pop_value);
          end
          if (out_item_o.status !== want.status) begin
            report_mismatch("status", 32'(want.status), 32'(out_item_o.status));
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_one_side(CmdPushOne, CmdPopOne, CmdPushTwo, CmdPopTwo);
    test_fill_one_side(CmdPushTwo, CmdPopTwo, CmdPushOne, CmdPopOne);
    test_stacks_meet();
    test_output_backpressure();
    test_random_mix(700);
    // allow for a stray late result
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never arrived", 32'(pending_results.size()), '0);
    end
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
